// ===== rtl/ska_pkg.sv =====
package ska_pkg;

    // operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SEED    = 3'd1;
    localparam logic [2:0] OP_KEY     = 3'd2;
    localparam logic [2:0] OP_LOCK    = 3'd3;
    localparam logic [2:0] OP_TIMEOUT = 3'd4;

    // access states
    localparam logic [1:0] ST_LOCKED    = 2'd0;
    localparam logic [1:0] ST_SEED_SENT = 2'd1;
    localparam logic [1:0] ST_UNLOCKED  = 2'd2;
    localparam logic [1:0] ST_DELAY     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SECURITY_LEVEL = 2'd0;
    localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd1;
    localparam logic [1:0] REG_DELAY_TICKS    = 2'd2;

    localparam logic [31:0] MIX_SEED_CONST = 32'h5C73_1A9B;
    localparam logic [31:0] MIX_ADD_CONST  = 32'h4D34_F521;

    localparam logic [7:0]  SECURITY_LEVEL_RST = 8'd0;
    localparam logic [2:0]  MAX_ATTEMPTS_RST   = 3'd3;
    localparam logic [19:0] DELAY_TICKS_RST    = 20'd10000;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] key_value;
    } ska_item_t;

    typedef struct packed {
        logic        accepted;
        logic [31:0] seed_value;
        logic [1:0]  state_code;
    } ska_result_t;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [19:0] data;
    } ska_cfg_t;

    // key mix: xor, rotate left 13, add, then xorshift / shift-add finish
    function automatic logic [31:0] expected_key(input logic [31:0] s);
        logic [31:0] k;
        begin
            k = s ^ MIX_SEED_CONST;
            k = {k[18:0], k[31:19]} + MIX_ADD_CONST;
            k = k ^ (k >> 7);
            k = k + (k << 11);
            k = k ^ (k >> 5);
            return k;
        end
    endfunction

endpackage

// ===== rtl/ska_item_if.sv =====
interface ska_item_if;
    import ska_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

// ===== rtl/ska_result_if.sv =====
interface ska_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] seed_value;
    logic [1:0]  state_code;

    modport source (output valid, output accepted, output seed_value, output state_code,
                    input ready);
    modport sink   (input valid, input accepted, input seed_value, input state_code,
                    output ready);
endinterface

// ===== rtl/ska_cfg_if.sv =====
interface ska_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ska_core.sv =====
module ska_core
    import ska_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  ska_item_t   item,
    input  ska_cfg_t    cfg,
    output ska_result_t result
);

    logic [7:0]  security_level_reg;
    logic [2:0]  max_attempts_reg;
    logic [19:0] delay_ticks_reg;

    logic [1:0]  access_state_reg, access_state_next;
    logic [31:0] time_now_reg, time_now_next;
    logic [31:0] stored_seed_reg, stored_seed_next;
    logic [2:0]  fail_count_reg, fail_count_next;
    logic [31:0] delay_until_reg, delay_until_next;

    logic        delay_expired;
    logic [2:0]  fail_inc;
    logic        ok;
    logic [31:0] seed_out;

    always_comb
    begin
        access_state_next = access_state_reg;
        time_now_next     = time_now_reg;
        stored_seed_next  = stored_seed_reg;
        fail_count_next   = fail_count_reg;
        delay_until_next  = delay_until_reg;
        ok                = 1'b0;
        seed_out          = 32'd0;
        delay_expired     = (access_state_reg == ST_DELAY) && (time_now_reg >= delay_until_reg);
        fail_inc          = fail_count_reg + 3'd1;

        case (item.operation)
            OP_TICK:
            begin
                time_now_next = time_now_reg + 32'd1;
                ok            = 1'b1;
            end
            OP_SEED:
            begin
                // an expired delay drops to locked before the request is judged
                if (delay_expired)
                begin
                    access_state_next = ST_LOCKED;
                end
                if (access_state_reg == ST_LOCKED || delay_expired)
                begin
                    stored_seed_next  = time_now_reg ^ (MIX_SEED_CONST + {24'd0, security_level_reg});
                    seed_out          = stored_seed_next;
                    access_state_next = ST_SEED_SENT;
                    ok                = 1'b1;
                end
            end
            OP_KEY:
            begin
                if (access_state_reg == ST_SEED_SENT)
                begin
                    if (item.key_value == expected_key(stored_seed_reg))
                    begin
                        access_state_next = ST_UNLOCKED;
                        fail_count_next   = 3'd0;
                        ok                = 1'b1;
                    end
                    else if (fail_inc >= max_attempts_reg)
                    begin
                        access_state_next = ST_DELAY;
                        delay_until_next  = time_now_reg + {12'd0, delay_ticks_reg};
                        fail_count_next   = 3'd0;
                    end
                    else
                    begin
                        access_state_next = ST_LOCKED;
                        fail_count_next   = fail_inc;
                    end
                end
            end
            OP_LOCK:
            begin
                access_state_next = ST_LOCKED;
                fail_count_next   = 3'd0;
                stored_seed_next  = 32'd0;
                ok                = 1'b1;
            end
            OP_TIMEOUT:
            begin
                if (delay_expired)
                begin
                    access_state_next = ST_LOCKED;
                    ok                = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        result.accepted   = ok;
        result.seed_value = seed_out;
        result.state_code = access_state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_state_reg <= ST_LOCKED;
            time_now_reg     <= 32'd0;
            stored_seed_reg  <= 32'd0;
            fail_count_reg   <= 3'd0;
            delay_until_reg  <= 32'd0;
        end
        else if (fire)
        begin
            access_state_reg <= access_state_next;
            time_now_reg     <= time_now_next;
            stored_seed_reg  <= stored_seed_next;
            fail_count_reg   <= fail_count_next;
            delay_until_reg  <= delay_until_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            security_level_reg <= SECURITY_LEVEL_RST;
            max_attempts_reg   <= MAX_ATTEMPTS_RST;
            delay_ticks_reg    <= DELAY_TICKS_RST;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                REG_SECURITY_LEVEL: security_level_reg <= cfg.data[7:0];
                REG_MAX_ATTEMPTS:   max_attempts_reg   <= cfg.data[2:0];
                REG_DELAY_TICKS:    delay_ticks_reg    <= cfg.data;
                default:            ;
            endcase
        end
    end

endmodule

// ===== rtl/seed_key_security_access_unit.sv =====
// Seed/key security access unit. Each item on req carries an operation (tick, request
// seed, send key, lock, timeout check) and a key; exactly one result item follows on rsp,
// giving whether the operation succeeded, the seed issued (zero unless a seed request
// succeeded) and the access state after the item. Items are taken one per clock unless rsp
// holds the result register: an item sits in an input register until the result register
// is free, the engine state is updated as it moves on, and it then lands in the result
// register. The state update (key mix, compares and the delay-end add) is combinational.
// Configuration writes on cfg are always ready and take effect at once; write them only
// while no item is in flight. The millisecond counter wraps silently, and lockout end
// times are not corrected for that wrap.
module seed_key_security_access_unit
    import ska_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    ska_item_if.sink     req,
    ska_result_if.source rsp,
    ska_cfg_if.sink      cfg
);

    // input stage
    logic        item_valid_reg;
    ska_item_t   item_reg;

    // result stage
    logic        rsp_valid_reg;
    ska_result_t rsp_reg;

    ska_result_t core_result;
    ska_cfg_t    core_cfg;
    logic        rsp_free;
    logic        fire;

    // result register can take a new item if empty or being drained this cycle
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign fire      = item_valid_reg && rsp_free;
    assign req.ready = !item_valid_reg || rsp_free;

    assign cfg.ready     = 1'b1;
    assign core_cfg.we    = cfg.valid;
    assign core_cfg.index = cfg.index;
    assign core_cfg.data  = cfg.data;

    ska_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (core_cfg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                item_valid_reg <= req.valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= item_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.operation <= req.operation;
            item_reg.key_value <= req.key_value;
        end
        if (fire)
        begin
            rsp_reg <= core_result;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.accepted   = rsp_reg.accepted;
    assign rsp.seed_value = rsp_reg.seed_value;
    assign rsp.state_code = rsp_reg.state_code;

endmodule
